@@ rtl/bltd_pkg.sv @@
package bltd_pkg;

  localparam int NUM_BUTTONS_DEF = 6;
  localparam int PIN_BITS        = 6;
  localparam int BTN_IDX_W       = 3;
  localparam int TICK_W          = 32;
  localparam int BACKOFF_W       = 16;
  localparam int RATE_W          = 20;
  localparam int THR_W           = BACKOFF_W + RATE_W;
  localparam int MS_PER_SEC      = 1000;
  localparam int LHS_W           = TICK_W + 10;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = RATE_W;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  localparam logic [BACKOFF_W-1:0] BACKOFF_RST = BACKOFF_W'(50);
  localparam logic [RATE_W-1:0]    RATE_RST    = RATE_W'(1000);

  typedef enum logic [1:0] {
    OP_PIN  = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BACKOFF_MS   = 4'd0,
    CFG_TICK_RATE_HZ = 4'd1
  } cfg_reg_t;

  typedef struct packed {
    op_t                  op;
    logic [PIN_BITS-1:0]  pin_levels;
    logic [BTN_IDX_W-1:0] button_sel;
  } item_t;

  typedef struct packed {
    logic [TICK_W-1:0]    event_count;
    logic [BTN_IDX_W-1:0] found_button;
    logic                 accepted;
    logic                 pin_found;
    logic                 read_pressed;
  } result_t;

endpackage

@@ rtl/bltd_cfg.sv @@
module bltd_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [bltd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bltd_pkg::CFG_DATA_W-1:0] wr_data,
  output logic [bltd_pkg::THR_W-1:0]      thresh
);
  import bltd_pkg::*;

  logic [BACKOFF_W-1:0] backoff_r;
  logic [BACKOFF_W-1:0] backoff_nxt;
  logic [RATE_W-1:0]    rate_r;
  logic [RATE_W-1:0]    rate_nxt;
  logic [THR_W-1:0]     thresh_r;

  always_comb begin
    backoff_nxt = backoff_r;
    rate_nxt    = rate_r;
    if (wr_en && wr_index == CFG_BACKOFF_MS) begin
      backoff_nxt = wr_data[BACKOFF_W-1:0];
    end
    if (wr_en && wr_index == CFG_TICK_RATE_HZ) begin
      rate_nxt = wr_data[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backoff_r <= BACKOFF_RST;
      rate_r    <= RATE_RST;
      thresh_r  <= THR_W'(BACKOFF_RST) * THR_W'(RATE_RST);
    end else begin
      backoff_r <= backoff_nxt;
      rate_r    <= rate_nxt;
      // update the lockout threshold at the same edge as the registers
      thresh_r  <= THR_W'(backoff_nxt) * THR_W'(rate_nxt);
    end
  end

  assign thresh = thresh_r;

endmodule

@@ rtl/bltd_core.sv @@
module bltd_core #(
  parameter int NUM_BUTTONS = bltd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       fire,
  input  bltd_pkg::item_t            item,
  input  logic [bltd_pkg::THR_W-1:0] thresh,
  output bltd_pkg::result_t          res
);
  import bltd_pkg::*;

  localparam int ScanN = (NUM_BUTTONS < PIN_BITS) ? NUM_BUTTONS : PIN_BITS;

  logic [NUM_BUTTONS-1:0] locked_r;
  logic [NUM_BUTTONS-1:0] latched_r;
  logic [TICK_W-1:0]      start_r [NUM_BUTTONS];
  logic [TICK_W-1:0]      tick_r;
  logic [TICK_W-1:0]      evcnt_r;
  logic [TICK_W-1:0]      evcnt_nxt;

  logic                   found;
  logic [BTN_IDX_W-1:0]   idx;
  logic [NUM_BUTTONS-1:0] hit_oh;
  logic [NUM_BUTTONS-1:0] rd_oh;
  logic [TICK_W-1:0]      sel_start;
  logic                   sel_locked;
  logic [TICK_W-1:0]      elapsed;
  logic [LHS_W-1:0]       lhs;
  logic                   expired;
  logic                   is_pin;
  logic                   acc;
  logic                   rd;

  // lowest-index low pin, then pick that button's lockout state
  always_comb begin
    found      = 1'b0;
    idx        = '0;
    hit_oh     = '0;
    rd_oh      = '0;
    sel_start  = '0;
    sel_locked = 1'b0;
    for (int i = ScanN - 1; i >= 0; i--) begin
      if (!item.pin_levels[i]) begin
        found = 1'b1;
        idx   = BTN_IDX_W'(i);
      end
    end
    for (int i = 0; i < ScanN; i++) begin
      hit_oh[i] = found && (idx == BTN_IDX_W'(i));
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      rd_oh[i] = (item.op == OP_READ) && (int'(item.button_sel) == i);
      if (hit_oh[i]) begin
        sel_start  = sel_start | start_r[i];
        sel_locked = sel_locked | locked_r[i];
      end
    end
  end

  assign is_pin    = (item.op == OP_PIN);
  assign elapsed   = tick_r - sel_start;
  assign lhs       = LHS_W'(elapsed) * LHS_W'(MS_PER_SEC);
  assign expired   = lhs >= LHS_W'(thresh);
  assign acc       = is_pin && found && (!sel_locked || expired);
  assign rd        = |(latched_r & rd_oh);
  assign evcnt_nxt = evcnt_r + TICK_W'(is_pin);

  always_comb begin
    res.read_pressed = rd;
    res.pin_found    = is_pin && found;
    res.accepted     = acc;
    res.found_button = (is_pin && found) ? idx : '0;
    res.event_count  = evcnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r  <= '0;
      latched_r <= '0;
      tick_r    <= '0;
      evcnt_r   <= '0;
    end else if (fire) begin
      evcnt_r <= evcnt_nxt;
      if (item.op == OP_TICK) begin
        tick_r <= tick_r + TICK_W'(1);
      end
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (acc && hit_oh[i]) begin
          locked_r[i]  <= 1'b1;
          latched_r[i] <= 1'b1;
        end
        if (rd_oh[i]) begin
          latched_r[i] <= 1'b0;
        end
      end
    end
  end

  // start time is only read while the button is locked out
  always_ff @(posedge clk) begin
    if (fire) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (acc && hit_oh[i]) begin
          start_r[i] <= tick_r;
        end
      end
    end
  end

endmodule

@@ rtl/button_lockout_debouncer_top.sv @@
// Button lockout debouncer. Each request on the in_ stream is one of: a pin
// change (op 0) carrying the six active-low button levels, a timer tick (op 1)
// that advances a free-running 32-bit tick count, a read (op 2) that returns
// and clears one button's pressed flag, or a no-op (op 3). A pin change counts
// itself and takes the lowest-index low button; its press is latched only if
// the button is not locked out or its lockout has run out, that is when
// (ticks since last accepted press) * 1000 >= backoff_ms * tick_rate_hz, with
// both products exact. Every request yields exactly one result on out_.
// Throughput is one request per clock while out_tready is high. A request
// taken on in_ is held in the input register, and its result is loaded into
// the result register and offered on out_; the single pass of priority scan,
// elapsed-time subtract, constant multiply and compare lies between those
// two registers. While out_tready is low the block holds two
// requests before in_tready drops. Configuration writes are always taken
// (cfg_ready is tied high); issue them only while the block is idle. The
// lockout threshold product is registered at the same edge as the write, so
// the new setting applies to every request processed after it.
module button_lockout_debouncer_top #(
  parameter int NUM_BUTTONS = bltd_pkg::NUM_BUTTONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [5:0] pin_levels, [8:6] button_sel, [15:9] zero
  input  logic [bltd_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] op
  input  logic [bltd_pkg::IN_TUSER_W-1:0]  in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] read_pressed, [1] pin_found, [2] accepted, [5:3] found_button,
  // [37:6] event_count, [39:38] zero
  output logic [bltd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // configuration writes: index 0 backoff_ms, 1 tick_rate_hz
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bltd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bltd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bltd_pkg::*;

  logic              s1_valid_r;
  item_t             s1_item_r;
  logic              out_valid_r;
  result_t           out_res_r;
  result_t           core_res;
  logic              out_load;
  logic [THR_W-1:0]  thresh;
  item_t             in_item;

  assign in_item.op         = op_t'(in_tuser[1:0]);
  assign in_item.pin_levels = in_tdata[PIN_BITS-1:0];
  assign in_item.button_sel = in_tdata[PIN_BITS +: BTN_IDX_W];

  // advance the held request into the result register when it is free
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign cfg_ready = 1'b1;

  bltd_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .thresh   (thresh)
  );

  // state updates land exactly when the result is loaded, so order holds
  bltd_core #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (out_load),
    .item   (s1_item_r),
    .thresh (thresh),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r <= in_item;
    end
    if (out_load) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r);

endmodule
